### hw/rtl/mhpq_pkg.sv
// Shared types, sizes and codes for the min-heap priority queue.
// Used by the heap store RAM user (top level); no dependencies of its own.
`timescale 1ns / 1ps

package mhpq_pkg;

  // Sizes of the heap and of one entry.
  localparam int CAPACITY = 64;
  localparam int PRIO_W   = 16;
  localparam int TAG_W    = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // Child positions reach 2*CAPACITY, so compares use two extra bits.
  localparam int CMP_W    = IDX_W + 2;

  // Stream payload widths.
  localparam int REQ_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int IN_DATA_W    = ((PRIO_W + TAG_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((PRIO_W + TAG_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_USER_W   = STATUS_W + 1;

  // Request codes; anything else behaves as a peek.
  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // One heap entry as held in the store.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

endpackage

### hw/rtl/mhpq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; holds the heap store for the priority queue.
`timescale 1ns / 1ps

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/min_heap_priority_queue.sv
// Top level of the binary min-heap priority queue: request stream in, result stream out.
// Depends on mhpq_pkg and on mhpq_ram, which holds the heap entries.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  tuser: req_type; tdata: priority, tag
//  m_*      out        m_tvalid/m_tready  tuser: status, top_valid;
//                                         tdata: top_priority, top_tag, entry_count
//
// A peek, a refused push or a pop that empties the heap goes straight to the result.
// A push walks up to log2(CAPACITY) levels, each a parent read, then compare and write.
// A pop reads the last entry and walks down level by level, each a left read, a right
// read if that child exists, then compare and write. The single RAM read port sets these
// steps. One request is in work at a time; reset empties the heap at once and needs no
// clearing pass. A waiting result does not stop the next request from being taken.

module min_heap_priority_queue
  import mhpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] entry_priority, [31:16] entry_tag
  input  logic [REQ_W-1:0]      s_tuser,   // [1:0] req_type
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] top_priority, [31:16] top_tag,
                                           // [38:32] entry_count, rest zero
  output logic [OUT_USER_W-1:0] m_tuser    // [1:0] status, [2] top_valid
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SU_RD  = 4'd1;
  localparam logic [3:0] S_SU_CMP = 4'd2;
  localparam logic [3:0] S_PO_LD  = 4'd3;
  localparam logic [3:0] S_SD_L   = 4'd4;
  localparam logic [3:0] S_SD_R   = 4'd5;
  localparam logic [3:0] S_SD_C   = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;

  logic [3:0]          state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [IDX_W-1:0]    pos, pos_next;
  logic [IDX_W-1:0]    par, par_next;
  logic [CMP_W-1:0]    lchild, lchild_next;
  logic                r_ok, r_ok_next;
  logic [STATUS_W-1:0] status, status_next;
  entry_t              cur, cur_next;
  entry_t              left_q, left_next;
  entry_t              root;

  logic                wr_en, rd_en;
  logic [IDX_W-1:0]    wr_addr, rd_addr;
  entry_t              wr_data, rd_data;

  logic                accept;
  logic                out_free;
  logic [CNT_W-1:0]    cnt_dec;
  logic [CMP_W-1:0]    cnt_ext, l_calc, r_calc;
  logic                pick_right;
  entry_t              child;
  logic [CMP_W-1:0]    child_pos;

  // Heap store.
  mhpq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign cnt_dec  = cnt - CNT_W'(1);
  assign cnt_ext  = CMP_W'(cnt);
  assign l_calc   = {1'b0, pos, 1'b1};
  assign r_calc   = lchild + CMP_W'(1);

  // Smaller child: the right one only when strictly smaller than the left.
  assign pick_right = r_ok && ($signed(rd_data.prio) < $signed(left_q.prio));
  assign child      = pick_right ? rd_data : left_q;
  assign child_pos  = pick_right ? r_calc : lchild;

  // Sequencer: next state, store accesses and working registers.
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    pos_next    = pos;
    par_next    = par;
    lchild_next = lchild;
    r_ok_next   = r_ok;
    status_next = status;
    cur_next    = cur;
    left_next   = left_q;
    wr_en       = 1'b0;
    wr_addr     = pos;
    wr_data     = cur;
    rd_en       = 1'b0;
    rd_addr     = pos;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur_next.prio = s_tdata[PRIO_W-1:0];
          cur_next.tag  = s_tdata[PRIO_W +: TAG_W];
          status_next   = ST_OK;
          state_next    = S_FIN;
          if (s_tuser == REQ_PUSH) begin
            if (cnt == CNT_W'(CAPACITY)) begin
              status_next = ST_FULL;
            end else begin
              pos_next   = cnt[IDX_W-1:0];
              cnt_next   = cnt + CNT_W'(1);
              state_next = S_SU_RD;
            end
          end else if (s_tuser == REQ_POP) begin
            if (cnt == '0) begin
              status_next = ST_EMPTY;
            end else begin
              cnt_next = cnt_dec;
              if (cnt_dec != '0) begin
                // Fetch the last entry; it goes to the root and sinks.
                rd_en      = 1'b1;
                rd_addr    = cnt_dec[IDX_W-1:0];
                state_next = S_PO_LD;
              end
            end
          end
        end
      end

      // Sift-up: fetch the parent, or settle at the root.
      S_SU_RD: begin
        if (pos == '0) begin
          wr_en      = 1'b1;
          state_next = S_FIN;
        end else begin
          par_next   = IDX_W'((pos - IDX_W'(1)) >> 1);
          rd_en      = 1'b1;
          rd_addr    = IDX_W'((pos - IDX_W'(1)) >> 1);
          state_next = S_SU_CMP;
        end
      end

      // Sift-up: stop at a parent that is not greater, else move it down.
      S_SU_CMP: begin
        wr_en = 1'b1;
        if ($signed(rd_data.prio) <= $signed(cur.prio)) begin
          state_next = S_FIN;
        end else begin
          wr_data    = rd_data;
          pos_next   = par;
          state_next = S_SU_RD;
        end
      end

      // Pop: the last entry becomes the sinking entry at the root.
      S_PO_LD: begin
        cur_next   = rd_data;
        pos_next   = '0;
        state_next = S_SD_L;
      end

      // Sift-down: fetch the left child, or settle at a leaf.
      S_SD_L: begin
        lchild_next = l_calc;
        if (l_calc >= cnt_ext) begin
          wr_en      = 1'b1;
          state_next = S_FIN;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = l_calc[IDX_W-1:0];
          state_next = S_SD_R;
        end
      end

      // Sift-down: keep the left child, fetch the right one if it exists.
      S_SD_R: begin
        left_next  = rd_data;
        r_ok_next  = (r_calc < cnt_ext);
        rd_en      = (r_calc < cnt_ext);
        rd_addr    = r_calc[IDX_W-1:0];
        state_next = S_SD_C;
      end

      // Sift-down: stop unless the smaller child is strictly smaller.
      S_SD_C: begin
        wr_en = 1'b1;
        if ($signed(child.prio) >= $signed(cur.prio)) begin
          state_next = S_FIN;
        end else begin
          wr_data    = child;
          pos_next   = child_pos[IDX_W-1:0];
          state_next = S_SD_L;
        end
      end

      // Hand the result over once the output register is free.
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    pos    <= pos_next;
    par    <= par_next;
    lchild <= lchild_next;
    r_ok   <= r_ok_next;
    status <= status_next;
    cur    <= cur_next;
    left_q <= left_next;
  end

  // Copy of the root entry, kept in step with every write to position zero.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == '0)) begin
      root <= wr_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      m_tuser <= {(cnt != '0), status};
      if (cnt != '0) begin
        m_tdata <= OUT_DATA_W'({cnt, root.tag, root.prio});
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule
